/* rtl/twtsc_pkg.sv */
package twtsc_pkg;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 24;
	localparam logic [CFG_IDX_W-1:0] REG_KP = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MIN = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MAX = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_NUM = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_THR = 3'd4;
	localparam logic [1:0] CMD_OVF = 2'd0;
	localparam logic [1:0] CMD_CAP_R = 2'd1;
	localparam logic [1:0] CMD_CAP_L = 2'd2;
	localparam logic [1:0] CMD_TICK = 2'd3;
	localparam logic [15:0] HALF_TURN_K = 16'd15204;
	localparam int DIV_W = 40;

	typedef struct packed {
		logic        start;
		logic [DIV_W-1:0] dividend;
		logic [DIV_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic        done;
		logic [DIV_W-1:0] quot;
	} div_rsp_t;
endpackage

/* rtl/twtsc_div.sv */
module twtsc_div
	import twtsc_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);
	logic [DIV_W-1:0] rem_q, quo_q, den_q;
	logic [5:0] cnt_q;
	logic busy_q;
	logic done_q;
	logic [DIV_W:0] trial;

	assign trial = {rem_q, quo_q[DIV_W-1]} - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q <= 6'(DIV_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= req.dividend;
			den_q <= req.divisor;
		end else if (busy_q) begin
			if (!trial[DIV_W]) begin
				rem_q <= trial[DIV_W-1:0];
				quo_q <= {quo_q[DIV_W-2:0], 1'b1};
			end else begin
				rem_q <= {rem_q[DIV_W-2:0], quo_q[DIV_W-1]};
				quo_q <= {quo_q[DIV_W-2:0], 1'b0};
			end
		end
	end

	assign rsp = {done_q, quo_q};
endmodule

/* rtl/two_wheel_tach_speed_controller.sv */
// A capture closing a block runs one division. A control tick runs one division when
// turning and one for each wheel with a positive period average before it raises
// its result.
// One beat at a time; input ready is low while a beat is worked on. A tick holds
// at its drive step while an earlier result waits. Reset clears all period, edge
// and latch state and loads register defaults.
module two_wheel_tach_speed_controller
	import twtsc_pkg::*;
#(
	parameter int AVG_LEN = 6,
	parameter int TIMER_SPAN = 65536
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic s_tvalid,
	output logic s_tready,
	input  logic [47:0] s_tdata, // cmd, capture_value, speed_knob, radius_pot
	output logic m_tvalid,
	input  logic m_tready,
	output logic [39:0] m_tdata // drive_left, drive_right, turning, zero pad
);
	localparam int CW = $clog2(AVG_LEN + 1);

	typedef enum logic [7:0] {
		ST_IDLE  = 8'b00000001,
		ST_CAP   = 8'b00000010,
		ST_AVG   = 8'b00000100,
		ST_TICK  = 8'b00001000,
		ST_DIFF  = 8'b00010000,
		ST_MEAS  = 8'b00100000,
		ST_DRIVE = 8'b01000000,
		ST_OUT   = 8'b10000000
	} state_t;

	state_t state_q;
	logic [11:0] kp_q;
	logic [7:0] min_q;
	logic [15:0] max_q;
	logic [23:0] num_q;
	logic [15:0] thr_q;
	logic [31:0] acc_q [2];
	logic [31:0] sum_q [2];
	logic [CW-1:0] cnt_q [2];
	logic [31:0] avg_q [2];
	logic [31:0] edge_q [2];
	logic turn_q;
	logic [47:0] in_q;
	logic w_q;
	logic wait_q;
	logic neg_q;
	logic [15:0] tgt_q;
	logic [15:0] diff_q;
	logic [16:0] wt_q;
	logic [15:0] dl_q;
	logic [39:0] meas_q;
	div_req_t req;
	div_rsp_t rsp;

	logic [1:0] cmd;
	logic [15:0] cap;
	logic [13:0] spot, rpot;
	logic [31:0] period, nsum, mag;
	logic [16:0] wtgt;
	logic signed [41:0] err;
	logic signed [54:0] prod;
	logic signed [46:0] adj, drv;
	logic [15:0] dres;
	logic [15:0] tgt_c, rad_c;

	assign cmd = in_q[1:0];
	assign cap = in_q[17:2];
	assign spot = in_q[31:18];
	assign rpot = in_q[45:32];
	assign tgt_c = 16'((17'(spot) * 17'd5) >> 3) + 16'd2560;
	assign rad_c = 16'((20'(rpot) * 20'd51) >> 5) + 16'd3840;
	assign period = acc_q[w_q] + 32'(cap);
	assign nsum = sum_q[w_q] + period;
	assign mag = nsum[31] ? (32'd0 - nsum) : nsum;
	assign wtgt = wt_q;
	assign err = $signed({25'd0, wtgt}) - $signed({2'b00, meas_q});
	assign prod = $signed({43'd0, kp_q}) * 55'(err);
	assign adj = 47'(prod >>> 8);
	assign drv = $signed({30'd0, wtgt}) + adj;
	always_comb begin
		if (wtgt < {1'b0, min_q, 8'd0}) dres = '0;
		else if (drv < 0) dres = '0;
		else if (drv > $signed({23'd0, max_q, 8'd0})) dres = max_q;
		else dres = 16'(drv >>> 8);
	end

	assign s_tready = (state_q == ST_IDLE);

	always_comb begin
		req = '0;
		case (state_q)
			ST_CAP: begin
				req.start = !wait_q && (32'(cnt_q[w_q]) + 32'd1 >= 32'(AVG_LEN));
				req.dividend = 40'(mag);
				req.divisor = 40'(AVG_LEN);
			end
			ST_DIFF: begin
				req.start = !wait_q;
				req.dividend = 40'(32'(tgt_q) * 32'(HALF_TURN_K));
				req.divisor = 40'(rad_c) << 13;
			end
			ST_MEAS: begin
				req.start = !wait_q && !avg_q[w_q][31] && (avg_q[w_q] != '0);
				req.dividend = {8'd0, num_q, 8'd0};
				req.divisor = 40'(avg_q[w_q]);
			end
			default: req = '0;
		endcase
	end

	twtsc_div u_div (.clk(clk), .arst_n(arst_n), .req(req), .rsp(rsp));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			kp_q <= 12'd256;
			min_q <= 8'd10;
			max_q <= 16'd2300;
			num_q <= 24'd1500000;
			thr_q <= 16'd156;
			for (int i = 0; i < 2; i++) begin
				acc_q[i] <= '0;
				sum_q[i] <= '0;
				cnt_q[i] <= '0;
				avg_q[i] <= '0;
				edge_q[i] <= '0;
			end
			turn_q <= 1'b0;
			m_tvalid <= 1'b0;
			wait_q <= 1'b0;
			w_q <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) m_tvalid <= 1'b0;
			if (cfg_we) begin
				case (cfg_index)
					REG_KP: kp_q <= cfg_data[11:0];
					REG_MIN: min_q <= cfg_data[7:0];
					REG_MAX: max_q <= cfg_data[15:0];
					REG_NUM: num_q <= cfg_data;
					REG_THR: thr_q <= cfg_data[15:0];
					default: ;
				endcase
			end
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						in_q <= s_tdata;
						wait_q <= 1'b0;
						case (s_tdata[1:0])
							CMD_OVF: state_q <= ST_AVG;
							CMD_CAP_R: begin w_q <= 1'b1; state_q <= ST_CAP; end
							CMD_CAP_L: begin w_q <= 1'b0; state_q <= ST_CAP; end
							default: state_q <= ST_TICK;
						endcase
					end
				end
				ST_AVG: begin
					acc_q[0] <= acc_q[0] + 32'(TIMER_SPAN);
					acc_q[1] <= acc_q[1] + 32'(TIMER_SPAN);
					state_q <= ST_IDLE;
				end
				ST_CAP: begin
					if (!wait_q) begin
						acc_q[w_q] <= 32'd0 - 32'(cap);
						edge_q[w_q] <= edge_q[w_q] + 32'd1;
						if (32'(cnt_q[w_q]) + 32'd1 >= 32'(AVG_LEN)) begin
							neg_q <= nsum[31];
							sum_q[w_q] <= nsum;
							cnt_q[w_q] <= '0;
							wait_q <= 1'b1;
						end else begin
							sum_q[w_q] <= nsum;
							cnt_q[w_q] <= cnt_q[w_q] + CW'(1);
							state_q <= ST_IDLE;
						end
					end else if (rsp.done) begin
						avg_q[w_q] <= neg_q ? 32'd0 - rsp.quot[31:0] : rsp.quot[31:0];
						sum_q[w_q] <= '0;
						state_q <= ST_IDLE;
					end
				end
				ST_TICK: begin
					if (edge_q[0] >= 32'(thr_q)) turn_q <= 1'b1;
					tgt_q <= tgt_c;
					diff_q <= '0;
					state_q <= (turn_q || edge_q[0] >= 32'(thr_q)) ? ST_DIFF : ST_MEAS;
					w_q <= 1'b0;
				end
				ST_DIFF: begin
					if (!wait_q) wait_q <= 1'b1;
					else if (rsp.done) begin
						diff_q <= rsp.quot[15:0];
						wait_q <= 1'b0;
						state_q <= ST_MEAS;
					end
				end
				ST_MEAS: begin
					wt_q <= w_q ? 17'(tgt_q) + 17'(diff_q) : 17'(tgt_q) - 17'(diff_q);
					if (!wait_q) begin
						if (req.start) wait_q <= 1'b1;
						else begin
							meas_q <= '0;
							state_q <= ST_DRIVE;
						end
					end else if (rsp.done) begin
						meas_q <= rsp.quot;
						wait_q <= 1'b0;
						state_q <= ST_DRIVE;
					end
				end
				ST_DRIVE: begin
					if (!w_q) begin
						dl_q <= dres;
						w_q <= 1'b1;
						state_q <= ST_MEAS;
					end else if (!m_tvalid || m_tready) begin
						state_q <= ST_OUT;
						m_tdata <= {7'd0, turn_q, dres, dl_q};
					end
				end
				ST_OUT: begin
					m_tvalid <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

/* bench/twtsc_checker.sv */
`timescale 1ns / 1ps

module twtsc_checker
	import twtsc_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  s_tvalid,
	input  logic                  s_tready,
	input  logic [47:0]           s_tdata,
	input  logic                  m_tvalid,
	input  logic                  m_tready,
	input  logic [39:0]           m_tdata,
	output int                    fail_count,
	output int                    pending
);
	localparam int BLOCK_LEN = 6;
	localparam int SPAN = 65536;

	typedef struct packed {
		logic [15:0] left;
		logic [15:0] right;
		logic        turning;
	} drive_t;

	drive_t      drive_q[$];
	logic [31:0] accum[2];
	logic [31:0] psum[2];
	logic [3:0]  cnt[2];
	logic [31:0] avg_period[2];
	logic [31:0] edges[2];
	logic        turn_on;
	longint      kp, min_spd, max_drv, numer, thresh;

	function automatic logic [15:0] wheel_drive(longint avg_s, longint tgt);
		longint meas, err, prod, adj, drv;
		meas = 0;
		if (tgt < min_spd * 256)
			return 16'd0;
		if (avg_s > 0)
			meas = (numer * 256) / avg_s;
		err = tgt - meas;
		prod = kp * err;
		adj = (prod >= 0) ? prod / 256 : -((-prod + 255) / 256);
		drv = tgt + adj;
		if (drv > max_drv * 256)
			drv = max_drv * 256;
		if (drv < 0)
			drv = 0;
		return 16'(drv / 256);
	endfunction

	task automatic close_period(int w, logic [15:0] cap);
		logic [31:0] period;
		longint s;
		period = accum[w] + {16'd0, cap};
		accum[w] = 32'd0 - {16'd0, cap};
		edges[w] = edges[w] + 1;
		cnt[w] = cnt[w] + 1;
		psum[w] = psum[w] + period;
		if (cnt[w] >= BLOCK_LEN) begin
			s = longint'($signed(psum[w]));
			avg_period[w] = 32'(s / BLOCK_LEN);
			cnt[w] = 0;
			psum[w] = 0;
		end
	endtask

	task automatic predict_tick(logic [13:0] spot, logic [13:0] rpot);
		longint tgt, rad, diff;
		drive_t d;
		diff = 0;
		if (longint'(edges[0]) >= thresh)
			turn_on = 1'b1;
		tgt = (5 * longint'(spot)) / 8 + 2560;
		rad = (51 * longint'(rpot)) / 32 + 3840;
		if (turn_on)
			diff = (tgt * longint'(HALF_TURN_K)) / (rad * 8192);
		d.left = wheel_drive(longint'($signed(avg_period[0])), tgt - diff);
		d.right = wheel_drive(longint'($signed(avg_period[1])), tgt + diff);
		d.turning = turn_on;
		drive_q.push_back(d);
	endtask

	always @(posedge clk or negedge arst_n) begin
		drive_t exp_d;
		if (!arst_n) begin
			drive_q.delete();
			for (int w = 0; w < 2; w++) begin
				accum[w] = 0;
				psum[w] = 0;
				cnt[w] = 0;
				avg_period[w] = 0;
				edges[w] = 0;
			end
			turn_on = 1'b0;
			kp = 256;
			min_spd = 10;
			max_drv = 2300;
			numer = 1500000;
			thresh = 156;
			fail_count = 0;
			pending = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_KP: kp = cfg_data[11:0];
					REG_MIN: min_spd = cfg_data[7:0];
					REG_MAX: max_drv = cfg_data[15:0];
					REG_NUM: numer = cfg_data[23:0];
					REG_THR: thresh = cfg_data[15:0];
					default: ;
				endcase
			end
			if (s_tvalid && s_tready) begin
				case (s_tdata[1:0])
					CMD_OVF: begin
						accum[0] = accum[0] + SPAN;
						accum[1] = accum[1] + SPAN;
					end
					CMD_CAP_R: close_period(1, s_tdata[17:2]);
					CMD_CAP_L: close_period(0, s_tdata[17:2]);
					default: predict_tick(s_tdata[31:18], s_tdata[45:32]);
				endcase
			end
			if (m_tvalid && m_tready) begin
				if (drive_q.size() == 0) begin
					$display("%0t: unexpected beat, expected none, actual %h", $time, m_tdata);
					fail_count++;
				end else begin
					exp_d = drive_q.pop_front();
					if (m_tdata[15:0] !== exp_d.left) begin
						$display("%0t: drive_left expected %0d actual %0d",
							$time, exp_d.left, m_tdata[15:0]);
						fail_count++;
					end
					if (m_tdata[31:16] !== exp_d.right) begin
						$display("%0t: drive_right expected %0d actual %0d",
							$time, exp_d.right, m_tdata[31:16]);
						fail_count++;
					end
					if (m_tdata[32] !== exp_d.turning) begin
						$display("%0t: turning expected %0b actual %0b",
							$time, exp_d.turning, m_tdata[32]);
						fail_count++;
					end
				end
			end
			pending = drive_q.size();
		end
	end
endmodule

/* bench/tb_two_wheel_tach_speed_controller.sv */
`timescale 1ns / 1ps

module tb_two_wheel_tach_speed_controller;
	import twtsc_pkg::*;

	localparam int CYCLE_LIMIT = 1000000;
	localparam int SETTLE = 300;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [47:0]           s_tdata;
	logic                  m_tvalid;
	logic                  m_tready;
	logic [39:0]           m_tdata;
	int                    fail_count;
	int                    pending;
	int                    cycles;
	bit                    quiet;
	bit                    hold_req;

	two_wheel_tach_speed_controller u_top (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	twtsc_checker u_chk (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.fail_count(fail_count), .pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb_two_wheel_tach_speed_controller failed");
			$finish;
		end
	end

	function automatic logic [47:0] pack_beat(logic [1:0] cmd, logic [15:0] cap,
		logic [13:0] spot, logic [13:0] rpot);
		return {2'b00, rpot, spot, cap, cmd};
	endfunction

	function automatic logic [13:0] pot_value();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0)
			return 14'd0;
		if (r == 1)
			return 14'h3FFF;
		return 14'($urandom);
	endfunction

	function automatic logic [47:0] random_beat();
		int r;
		logic [1:0] cmd;
		r = $urandom_range(0, 99);
		if (r < 20)
			cmd = CMD_OVF;
		else if (r < 45)
			cmd = CMD_CAP_R;
		else if (r < 70)
			cmd = CMD_CAP_L;
		else
			cmd = CMD_TICK;
		return pack_beat(cmd, 16'($urandom), pot_value(), pot_value());
	endfunction

	task automatic send_beat(logic [47:0] beat);
		if (!quiet && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= beat;
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic load_regs(logic [23:0] kp, logic [23:0] mn, logic [23:0] mx,
		logic [23:0] num, logic [23:0] thr);
		logic [23:0] vals[5];
		vals = '{kp, mn, mx, num, thr};
		for (int i = 0; i < 5; i++) begin
			cfg_we <= 1'b1;
			cfg_index <= CFG_IDX_W'(i);
			cfg_data <= vals[i];
			@(posedge clk);
		end
		cfg_index <= CFG_IDX_W'(5 + $urandom_range(0, 2));
		cfg_data <= 24'($urandom);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic random_run(int n);
		for (int i = 0; i < n; i++)
			send_beat(random_beat());
	endtask

	always begin
		m_tready <= 1'b1;
		repeat ($urandom_range(1, 30)) @(posedge clk);
		if (hold_req) begin
			hold_req = 1'b0;
			m_tready <= 1'b0;
			repeat (800) @(posedge clk);
		end else if (!quiet) begin
			m_tready <= 1'b0;
			repeat ($urandom_range(1, 17)) @(posedge clk);
		end
	end

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		cycles = 0;
		quiet = 1'b0;
		hold_req = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_beat(pack_beat(CMD_TICK, 16'h0000, 14'd0, 14'd0));
		send_beat(pack_beat(CMD_TICK, 16'hFFFF, 14'h3FFF, 14'h3FFF));
		send_beat(pack_beat(CMD_OVF, 16'hFFFF, 14'h3FFF, 14'h3FFF));
		send_beat(pack_beat(CMD_CAP_R, 16'hFFFF, 14'd0, 14'd0));
		send_beat(pack_beat(CMD_CAP_L, 16'h0000, 14'd0, 14'd0));
		for (int i = 0; i < 6; i++) begin
			send_beat(pack_beat(CMD_OVF, 16'd0, 14'd0, 14'd0));
			send_beat(pack_beat(CMD_CAP_L, 16'd1000, 14'd0, 14'd0));
			send_beat(pack_beat(CMD_CAP_R, 16'hFFFF, 14'd0, 14'd0));
		end
		send_beat(pack_beat(CMD_TICK, 16'd0, 14'h3FFF, 14'd0));
		send_beat(pack_beat(CMD_TICK, 16'd0, 14'd8000, 14'h2AAA));
		drain();

		load_regs(24'd4095, 24'd0, 24'd65535, 24'hFFFFFF, 24'd0);
		send_beat(pack_beat(CMD_TICK, 16'd0, 14'd0, 14'h3FFF));
		send_beat(pack_beat(CMD_TICK, 16'd0, 14'h3FFF, 14'd0));
		random_run(200);
		hold_req = 1'b1;
		random_run(60);
		drain();

		load_regs(24'd0, 24'd255, 24'd0, 24'd1, 24'd65535);
		random_run(120);
		drain();

		load_regs(24'd255, 24'd255, 24'd65535, 24'd1, 24'd0);
		random_run(80);
		drain();

		load_regs(24'($urandom_range(64, 1024)), 24'($urandom_range(0, 40)),
			24'($urandom_range(1000, 8000)), 24'($urandom_range(100000, 4000000)),
			24'($urandom_range(0, 300)));
		random_run(160);
		quiet = 1'b1;
		random_run(100);
		drain();

		if (fail_count == 0)
			$display("tb_two_wheel_tach_speed_controller passed");
		else
			$display("tb_two_wheel_tach_speed_controller failed");
		$finish;
	end
endmodule
